// File: src/gvi_pkg.sv
// Shared types and constants for the grid vector interpolator.
`timescale 1ns / 1ps
package gvi_pkg;
    localparam int unsigned CoordW = 24;
    localparam int unsigned AddrW  = 10;
    localparam int unsigned CfgW   = 6;
    localparam int unsigned StoreDepth = 1024;
    localparam int unsigned DiffW  = 25;
    localparam int unsigned ProdW  = 50;

    localparam logic [1:0] StatusOk    = 2'd0;
    localparam logic [1:0] StatusSmall = 2'd1;
    localparam logic [1:0] StatusZero  = 2'd2;

    localparam logic CmdLoad  = 1'b0;
    localparam logic CmdQuery = 1'b1;

    localparam logic RegCols = 1'b0;
    localparam logic RegRows = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SX_RD,     // read x[k], x[k+1]
        ST_SX_CHK,
        ST_SY_RD,
        ST_SY_CHK,
        ST_AN_RD,     // read anchor and x-neighbor
        ST_AX_CAP,
        ST_AY_RD,     // read y-neighbor
        ST_AY_CAP,
        ST_MUL,       // one product per pass
        ST_DIV,       // serial divider
        ST_ACC,
        ST_OUT
    } t_state;

    // Request flags toward the sequencer.
    typedef struct packed {
        logic div_done;
        logic srch_hit;
        logic srch_last;
    } t_flags;
endpackage

// File: src/gvi_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps
module gvi_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

// File: src/grid_vector_interpolator_unit.sv
// Grid vector interpolator: reference grid stores, interval search, serial divides.
// Operation: a load is written at its accepting edge and the block stays ready;
//   a query runs two linear searches (a read and a check per step), reads the anchor
//   and its two neighbours, then makes four passes of one multiply, fifty restoring
//   quotient bits and one accumulate (a zero gradient skips its division). A grid
//   smaller than 2 by 2 answers in the cycle after acceptance.
// Throughput: one request at a time; the block is not ready until the result is taken.
// Reset: synchronous active-low i_rst_n; ref_cols and ref_rows return to 32,
//   store contents are undefined until loaded.
`timescale 1ns / 1ps
module grid_vector_interpolator_unit #(
    parameter int unsigned MAX_COLS = 32,
    parameter int unsigned MAX_ROWS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic [gvi_pkg::AddrW-1:0]     i_ref_index,
    input  logic signed [gvi_pkg::CoordW-1:0] i_pos_x,
    input  logic signed [gvi_pkg::CoordW-1:0] i_pos_y,
    input  logic signed [gvi_pkg::CoordW-1:0] i_vel_u,
    input  logic signed [gvi_pkg::CoordW-1:0] i_vel_v,
    input  logic                          i_last_query,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [gvi_pkg::CoordW-1:0] o_interp_u,
    output logic signed [gvi_pkg::CoordW-1:0] o_interp_v,
    output logic [1:0]                    o_status,
    output logic                          o_last_point
);
    import gvi_pkg::*;

    // Clamp bounds fit the 6-bit register fields.
    localparam logic [8:0] ColsCap = 9'(MAX_COLS);
    localparam logic [8:0] RowsCap = 9'(MAX_ROWS);

    // ---------------- configuration ----------------
    logic [CfgW-1:0] r_cols, r_rows;
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CfgW'(32);
            r_rows <= CfgW'(32);
        end else if (cfg_wr && paddr[2] == RegCols && paddr[1:0] == 2'b00) begin
            r_cols <= pwdata[CfgW-1:0];
        end else if (cfg_wr && paddr[2] == RegRows && paddr[1:0] == 2'b00) begin
            r_rows <= pwdata[CfgW-1:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr[2] == RegCols) prdata[CfgW-1:0] = r_cols;
        else                     prdata[CfgW-1:0] = r_rows;
    end

    // Effective grid size, clamped to the build maximum.
    logic [8:0] cols_e, rows_e;
    assign cols_e = ({3'b0, r_cols} > ColsCap) ? ColsCap : {3'b0, r_cols};
    assign rows_e = ({3'b0, r_rows} > RowsCap) ? RowsCap : {3'b0, r_rows};

    // ---------------- state and request capture ----------------
    t_state r_state, n_state;
    logic signed [CoordW-1:0] r_px, r_py;
    logic r_last;
    logic [8:0] r_k;            // search step
    logic [8:0] r_j;            // chosen column
    logic [AddrW-1:0] r_rowaddr; // k * cols, kept incrementally
    logic [AddrW-1:0] r_anchor;
    logic [1:0] r_pass;         // which of four gradient terms
    logic signed [CoordW-1:0] r_xa, r_ya, r_ua, r_va, r_xb, r_ub, r_vb, r_yc, r_uc, r_vc;
    // Wide enough for the anchor plus two full-size terms before saturation.
    logic signed [ProdW+1:0] r_acc_u, r_acc_v;
    logic [1:0] r_stat;

    logic acc_in, load_we;
    assign acc_in  = i_valid && o_ready;
    assign load_we = acc_in && i_cmd == CmdLoad;

    // ---------------- stores ----------------
    logic [AddrW-1:0] ra, rb;
    logic [CoordW-1:0] xa_q, xb_q, ya_q, yb_q, ua_q, ub_q, va_q, vb_q;
    gvi_ram #(.WIDTH(CoordW), .DEPTH(StoreDepth)) u_xs (.i_clk, .i_we(load_we),
        .i_waddr(i_ref_index), .i_wdata(i_pos_x), .i_raddr_a(ra), .i_raddr_b(rb),
        .o_rdata_a(xa_q), .o_rdata_b(xb_q));
    gvi_ram #(.WIDTH(CoordW), .DEPTH(StoreDepth)) u_ys (.i_clk, .i_we(load_we),
        .i_waddr(i_ref_index), .i_wdata(i_pos_y), .i_raddr_a(ra), .i_raddr_b(rb),
        .o_rdata_a(ya_q), .o_rdata_b(yb_q));
    gvi_ram #(.WIDTH(CoordW), .DEPTH(StoreDepth)) u_us (.i_clk, .i_we(load_we),
        .i_waddr(i_ref_index), .i_wdata(i_vel_u), .i_raddr_a(ra), .i_raddr_b(rb),
        .o_rdata_a(ua_q), .o_rdata_b(ub_q));
    gvi_ram #(.WIDTH(CoordW), .DEPTH(StoreDepth)) u_vs (.i_clk, .i_we(load_we),
        .i_waddr(i_ref_index), .i_wdata(i_vel_v), .i_raddr_a(ra), .i_raddr_b(rb),
        .o_rdata_a(va_q), .o_rdata_b(vb_q));

    // Read addresses per state; all wrap modulo the store depth.
    always_comb begin
        ra = '0;
        rb = '0;
        unique case (r_state)
            ST_SX_RD: begin
                ra = AddrW'(r_k);
                rb = AddrW'(r_k + 9'd1);
            end
            ST_SY_RD: begin
                ra = r_rowaddr;
                rb = r_rowaddr + AddrW'(cols_e);
            end
            ST_AN_RD: begin
                ra = r_anchor;
                rb = r_anchor + AddrW'(1);
            end
            ST_AY_RD: begin
                ra = r_anchor;
                rb = r_anchor + AddrW'(cols_e);
            end
            default: begin
                ra = '0;
                rb = '0;
            end
        endcase
    end

    // ---------------- search compare ----------------
    t_flags flg;
    logic signed [CoordW-1:0] s_lo, s_hi, s_p;
    always_comb begin
        if (r_state == ST_SX_CHK) begin
            s_lo = xa_q; s_hi = xb_q; s_p = r_px;
        end else begin
            s_lo = ya_q; s_hi = yb_q; s_p = r_py;
        end
    end
    logic [8:0] n_lim;
    assign n_lim = (r_state == ST_SX_CHK) ? cols_e : rows_e;
    assign flg.srch_hit  = (r_k == 9'd0 && s_p < s_lo) || (s_p >= s_lo && s_p < s_hi);
    assign flg.srch_last = (r_k + 9'd2 >= n_lim);

    // ---------------- shared multiply and serial divider ----------------
    // pass 0: du_x*dx/dX, 1: dv_x*dx/dX, 2: du_y*dy/dY, 3: dv_y*dy/dY
    logic signed [DiffW-1:0] m_a, m_b, den;
    always_comb begin
        unique case (r_pass)
            2'd0: begin m_a = DiffW'(r_ub) - DiffW'(r_ua); m_b = DiffW'(r_px) - DiffW'(r_xa); end
            2'd1: begin m_a = DiffW'(r_vb) - DiffW'(r_va); m_b = DiffW'(r_px) - DiffW'(r_xa); end
            2'd2: begin m_a = DiffW'(r_uc) - DiffW'(r_ua); m_b = DiffW'(r_py) - DiffW'(r_ya); end
            default: begin
                m_a = DiffW'(r_vc) - DiffW'(r_va); m_b = DiffW'(r_py) - DiffW'(r_ya);
            end
        endcase
        den = r_pass[1] ? (DiffW'(r_yc) - DiffW'(r_ya)) : (DiffW'(r_xb) - DiffW'(r_xa));
    end

    logic [ProdW-1:0] r_num, r_quo;   // magnitudes
    logic [ProdW-1:0] r_rem;
    logic [DiffW-1:0] r_dmag;
    logic r_neg;
    logic [5:0] r_bit;
    logic signed [ProdW-1:0] prod;
    assign prod = m_a * m_b;
    logic [ProdW:0] rem_sh;
    assign rem_sh = {r_rem, r_num[ProdW-1]};
    logic rem_ge;
    assign rem_ge = rem_sh >= {{(ProdW-DiffW+1){1'b0}}, r_dmag};
    assign flg.div_done = (r_bit == 6'd0);

    logic signed [ProdW:0] term_s;
    assign term_s = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    logic den_zero;
    assign den_zero = (den == '0);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (acc_in && i_cmd == CmdQuery) begin
                n_state = (cols_e < 9'd2 || rows_e < 9'd2) ? ST_OUT : ST_SX_RD;
            end
            ST_SX_RD:  n_state = ST_SX_CHK;
            ST_SX_CHK: n_state = (flg.srch_hit || flg.srch_last) ? ST_SY_RD : ST_SX_RD;
            ST_SY_RD:  n_state = ST_SY_CHK;
            ST_SY_CHK: n_state = (flg.srch_hit || flg.srch_last) ? ST_AN_RD : ST_SY_RD;
            ST_AN_RD:  n_state = ST_AX_CAP;
            ST_AX_CAP: n_state = ST_AY_RD;
            ST_AY_RD:  n_state = ST_AY_CAP;
            ST_AY_CAP: n_state = ST_MUL;
            ST_MUL:    n_state = den_zero ? ST_ACC : ST_DIV;
            ST_DIV:    n_state = flg.div_done ? ST_ACC : ST_DIV;
            ST_ACC:    n_state = (r_pass == 2'd3) ? ST_OUT : ST_MUL;
            ST_OUT:    if (i_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // ---------------- outputs ----------------
    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_OUT:  o_valid = 1'b1;
            default: begin
                o_ready = 1'b0;
                o_valid = 1'b0;
            end
        endcase
    end

    // Saturate accumulators to 24 bits.
    function automatic logic [CoordW-1:0] sat(input logic signed [ProdW+1:0] x);
        if (x > $signed((ProdW+2)'(24'sh7FFFFF)))                    sat = 24'h7FFFFF;
        else if (x < $signed({{(ProdW+2-CoordW){1'b1}}, 24'h800000})) sat = 24'h800000;
        else                                                          sat = x[CoordW-1:0];
    endfunction

    assign o_interp_u   = r_stat == StatusSmall ? '0 : sat(r_acc_u);
    assign o_interp_v   = r_stat == StatusSmall ? '0 : sat(r_acc_v);
    assign o_status     = r_stat;
    assign o_last_point = r_last;

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        unique case (r_state)
            ST_IDLE: begin
                // hold query coordinates and clear search state
                r_px <= i_pos_x;
                r_py <= i_pos_y;
                r_last <= i_last_query;
                r_k <= '0;
                r_rowaddr <= '0;
                r_pass <= '0;
                r_stat <= (cols_e < 9'd2 || rows_e < 9'd2) ? StatusSmall : StatusOk;
            end
            ST_SX_CHK: begin
                if (flg.srch_hit) r_j <= r_k;
                else if (flg.srch_last) r_j <= n_lim - 9'd2;
                if (flg.srch_hit || flg.srch_last) r_k <= '0;
                else r_k <= r_k + 9'd1;
            end
            ST_SY_CHK: begin
                if (flg.srch_hit || flg.srch_last) begin
                    // anchor = row base + column; last interval clamps row base
                    if (flg.srch_hit) r_anchor <= r_rowaddr + AddrW'(r_j);
                    else r_anchor <= r_rowaddr + AddrW'(r_j);
                end else begin
                    r_k <= r_k + 9'd1;
                    r_rowaddr <= r_rowaddr + AddrW'(cols_e);
                end
            end
            ST_AX_CAP: begin
                r_xa <= xa_q; r_ya <= ya_q; r_ua <= ua_q; r_va <= va_q;
                r_xb <= xb_q; r_ub <= ub_q; r_vb <= vb_q;
            end
            ST_AY_CAP: begin
                r_yc <= yb_q; r_uc <= ub_q; r_vc <= vb_q;
                r_acc_u <= (ProdW+2)'(r_ua);
                r_acc_v <= (ProdW+2)'(r_va);
            end
            ST_MUL: begin
                r_num  <= prod[ProdW-1] ? ProdW'(-prod) : ProdW'(prod);
                r_neg  <= prod[ProdW-1] ^ den[DiffW-1];
                r_dmag <= den[DiffW-1] ? DiffW'(-den) : DiffW'(den);
                r_rem  <= '0;
                r_quo  <= '0;
                // one quotient bit per cycle; the last one lands as the count hits zero
                r_bit  <= 6'(ProdW - 1);
                if (den_zero) r_stat <= StatusZero;
            end
            ST_DIV: begin
                // one restoring quotient bit per cycle
                r_rem <= rem_ge ? ProdW'(rem_sh - (ProdW+1)'(r_dmag)) : ProdW'(rem_sh);
                r_quo <= {r_quo[ProdW-2:0], rem_ge};
                r_num <= {r_num[ProdW-2:0], 1'b0};
                r_bit <= r_bit - 6'd1;
            end
            ST_ACC: begin
                if (!den_zero) begin
                    if (!r_pass[0]) r_acc_u <= r_acc_u + (ProdW+2)'(term_s);
                    else            r_acc_v <= r_acc_v + (ProdW+2)'(term_s);
                end
                r_pass <= r_pass + 2'd1;
            end
            default: begin
            end
        endcase
    end
endmodule

// File: src/gvi_checker.sv
// Port-level assertions for the grid vector interpolator.
`timescale 1ns / 1ps
module gvi_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_status,
    input logic       o_last_point
);
    import gvi_pkg::*;

    // Never ready while a result is pending.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready during result");
    // Status code is always legal.
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == StatusOk || o_status == StatusSmall ||
                     o_status == StatusZero)) else $error("bad status");
    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_last_point))
        else $error("result dropped");
    // After a result is taken, the block is ready.
    a_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> o_ready) else $error("no return to ready");
endmodule

bind grid_vector_interpolator_unit gvi_checker u_gvi_checker (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready, .o_status, .o_last_point
);

// File: verif/tb_top.sv
// Self-checking testbench for the grid vector interpolator unit.
`timescale 1ns / 1ps
module tb_top;
    import gvi_pkg::*;

    localparam int CycleLimit = 3000000;
    localparam int IdleGap    = 10;    // a load is written at acceptance; leave margin
    localparam int HoldCycles = 400;   // long receiver hold-off
    localparam logic [2:0] AddrCols = {RegCols, 2'b00};
    localparam logic [2:0] AddrRows = {RegRows, 2'b00};

    typedef enum logic {ROW_CFG, ROW_REQ} t_row_kind;

    // One grid request as seen on the input channel.
    typedef struct {
        logic                     cmd;
        logic [AddrW-1:0]         idx;
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] u;
        logic signed [CoordW-1:0] v;
        logic                     last;
    } t_grid_req;

    // One interpolated vector with its status.
    typedef struct {
        logic signed [CoordW-1:0] u;
        logic signed [CoordW-1:0] v;
        logic [1:0]               st;
        logic                     last;
    } t_vec_out;

    // Directed row: either a register write or a request, with an optional typed result.
    typedef struct {
        t_row_kind  kind;
        logic [2:0] addr;
        int         value;
        t_grid_req  req;
        bit         typed;
        t_vec_out   res;
    } t_dir_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]               paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic                     i_cmd = CmdLoad;
    logic [AddrW-1:0]         i_ref_index = '0;
    logic signed [CoordW-1:0] i_pos_x = '0, i_pos_y = '0, i_vel_u = '0, i_vel_v = '0;
    logic                     i_last_query = 1'b0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [CoordW-1:0] o_interp_u, o_interp_v;
    logic [1:0]               o_status;
    logic                     o_last_point;

    grid_vector_interpolator_unit u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state: mirror of the four stores and both registers.
    int        grid_x[StoreDepth];
    int        grid_y[StoreDepth];
    int        grid_u[StoreDepth];
    int        grid_v[StoreDepth];
    int        cols_reg = 32;
    int        rows_reg = 32;
    t_vec_out  pending_vecs[$];
    int        fails = 0;
    int        cycles = 0;
    bit        quiet = 1'b0;      // no idling on either side
    bit        hold_req = 1'b0;   // ask the receiver for a long hold-off

    // Linear interval search over row 0 (x) or column 0 (y).
    function automatic int find_interval(bit along_y, int p, int n, int stride);
        int lo, hi;
        for (int k = 0; k + 1 < n; k++) begin
            lo = along_y ? grid_y[(k * stride) % StoreDepth] : grid_x[(k * stride) % StoreDepth];
            hi = along_y ? grid_y[((k + 1) * stride) % StoreDepth]
                         : grid_x[((k + 1) * stride) % StoreDepth];
            if (k == 0 && p < lo) return 0;
            if (p >= lo && p < hi) return k;
        end
        return n - 2;
    endfunction

    function automatic longint clamp24(longint val);
        if (val > 64'sd8388607) return 64'sd8388607;
        if (val < -64'sd8388608) return -64'sd8388608;
        return val;
    endfunction

    // Apply a request to the mirror; return 1 with the expected vector on a query.
    function automatic bit interpolate(t_grid_req r, output t_vec_out res);
        int cols, rows, cj, ri, a, ax, ay;
        longint u, v, dxx, dyy, ddx, ddy;
        res.last = r.last;
        res.st   = StatusOk;
        if (r.cmd == CmdLoad) begin
            grid_x[r.idx] = int'(r.x);
            grid_y[r.idx] = int'(r.y);
            grid_u[r.idx] = int'(r.u);
            grid_v[r.idx] = int'(r.v);
            return 1'b0;
        end
        cols = (cols_reg > 32) ? 32 : cols_reg;
        rows = (rows_reg > 32) ? 32 : rows_reg;
        if (cols < 2 || rows < 2) begin
            res.u  = '0;
            res.v  = '0;
            res.st = StatusSmall;
            return 1'b1;
        end
        cj = find_interval(1'b0, int'(r.x), cols, 1);
        ri = find_interval(1'b1, int'(r.y), rows, cols);
        a  = (ri * cols + cj) % StoreDepth;
        ax = (a + 1) % StoreDepth;
        ay = (a + cols) % StoreDepth;
        u   = grid_u[a];
        v   = grid_v[a];
        dxx = longint'(grid_x[ax]) - grid_x[a];
        dyy = longint'(grid_y[ay]) - grid_y[a];
        ddx = longint'(r.x) - grid_x[a];
        ddy = longint'(r.y) - grid_y[a];
        if (dxx != 0) begin
            u += ((longint'(grid_u[ax]) - grid_u[a]) * ddx) / dxx;
            v += ((longint'(grid_v[ax]) - grid_v[a]) * ddx) / dxx;
        end else begin
            res.st = StatusZero;
        end
        if (dyy != 0) begin
            u += ((longint'(grid_u[ay]) - grid_u[a]) * ddy) / dyy;
            v += ((longint'(grid_v[ay]) - grid_v[a]) * ddy) / dyy;
        end else begin
            res.st = StatusZero;
        end
        res.u = CoordW'(clamp24(u));
        res.v = CoordW'(clamp24(v));
        return 1'b1;
    endfunction

    function automatic int rand_range(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Offer one request; wait for acceptance, then record what it should produce.
    task automatic send_req(t_grid_req r, bit typed, t_vec_out typed_res);
        t_vec_out res;
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = int'($urandom_range(1, 3));
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_cmd        <= r.cmd;
        i_ref_index  <= r.idx;
        i_pos_x      <= r.x;
        i_pos_y      <= r.y;
        i_vel_u      <= r.u;
        i_vel_v      <= r.v;
        i_last_query <= r.last;
        do @(posedge i_clk); while (!o_ready);
        if (interpolate(r, res)) pending_vecs.push_back(typed ? typed_res : res);
    endtask

    // Let the block drain, including a trailing load that has no result.
    task automatic wait_drained();
        while (pending_vecs.size() != 0) @(posedge i_clk);
        repeat (IdleGap) @(posedge i_clk);
    endtask

    // Register write while idle, then read it back.
    task automatic write_reg(logic [2:0] addr, int value);
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_drained();
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= value; penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == AddrCols) cols_reg = value & 63;
        else rows_reg = value & 63;
        @(negedge i_clk);
        pwrite <= 1'b0; penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[CfgW-1:0] != CfgW'(value)) begin
            $error("register %0d expected %0d got %0d", addr, value & 63, prdata[CfgW-1:0]);
            fails++;
        end
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
    endtask

    // Load a well-formed grid, then query it with mostly in-range points.
    task automatic run_phase(int cols_val, int rows_val, int n_query);
        t_grid_req r;
        t_vec_out none;
        int cols, rows, bx, by, sx, sy, xs[32], ys[32], span_x, span_y;
        none = '{default: '0};
        write_reg(AddrCols, cols_val);
        write_reg(AddrRows, rows_val);
        cols = (cols_val > 32) ? 32 : cols_val;
        rows = (rows_val > 32) ? 32 : rows_val;
        sx = int'($urandom_range(1, 250000));
        sy = int'($urandom_range(1, 250000));
        bx = rand_range(-8388608, 0);
        by = rand_range(-8388608, 0);
        xs[0] = bx;
        ys[0] = by;
        // Occasionally repeat a coordinate so that a zero gradient shows up.
        for (int k = 1; k < 32; k++) begin
            xs[k] = xs[k - 1] + (($urandom_range(0, 5) == 0) ? 0 : int'($urandom_range(1, sx)));
            ys[k] = ys[k - 1] + (($urandom_range(0, 5) == 0) ? 0 : int'($urandom_range(1, sy)));
        end
        span_x = xs[cols - 1] - bx;
        span_y = ys[rows - 1] - by;
        for (int ri = 0; ri < rows; ri++) begin
            for (int cj = 0; cj < cols; cj++) begin
                r.cmd  = CmdLoad;
                r.idx  = AddrW'(ri * cols + cj);
                r.x    = CoordW'(xs[cj] + rand_range(-50, 50) * (ri != 0));
                r.y    = CoordW'(ys[ri] + rand_range(-50, 50) * (cj != 0));
                r.u    = CoordW'(($urandom_range(0, 7) == 0) ? int'($urandom())
                                                             : rand_range(-40000, 40000));
                r.v    = CoordW'(($urandom_range(0, 7) == 0) ? int'($urandom())
                                                             : rand_range(-40000, 40000));
                r.last = 1'($urandom_range(0, 1));
                send_req(r, 1'b0, none);
            end
        end
        for (int q = 0; q < n_query; q++) begin
            // Hold off the receiver while queries keep coming, so the input stalls.
            if (q == 0 && cols_val == 4) hold_req = 1'b1;
            r.cmd  = CmdQuery;
            r.idx  = AddrW'($urandom());
            r.u    = CoordW'($urandom());
            r.v    = CoordW'($urandom());
            r.last = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 4) == 0) begin
                r.x = CoordW'($urandom());
                r.y = CoordW'($urandom());
            end else begin
                r.x = CoordW'(bx + rand_range(-1000, span_x + 1000));
                r.y = CoordW'(by + rand_range(-1000, span_y + 1000));
            end
            // Noise: rewrite a grid entry in use with random content.
            if ($urandom_range(0, 9) == 0) begin
                r.cmd = CmdLoad;
                r.idx = AddrW'($urandom_range(0, cols * rows - 1));
                r.x   = CoordW'($urandom());
                r.y   = CoordW'($urandom());
            end
            send_req(r, 1'b0, none);
            if (q == n_query / 2 && cols_val == 63) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                while (pending_vecs.size() != 0) @(posedge i_clk);
            end
        end
    endtask

    // Receiver: random ready bursts, one long hold-off on request, steady when quiet.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HoldCycles - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (quiet) begin
                i_ready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                i_ready <= (stall == 0);
            end else if ($urandom_range(0, 3) == 0) begin
                stall = int'($urandom_range(1, 3));
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_vec_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_vecs.size() == 0) begin
                $error("result with no request outstanding");
                fails++;
            end else begin
                want = pending_vecs.pop_front();
                if (o_interp_u !== want.u) begin
                    $error("interp_u expected %0d got %0d", want.u, o_interp_u);
                    fails++;
                end
                if (o_interp_v !== want.v) begin
                    $error("interp_v expected %0d got %0d", want.v, o_interp_v);
                    fails++;
                end
                if (o_status !== want.st) begin
                    $error("status expected %0d got %0d", want.st, o_status);
                    fails++;
                end
                if (o_last_point !== want.last) begin
                    $error("last_point expected %0d got %0d", want.last, o_last_point);
                    fails++;
                end
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin
        t_dir_row  rows_tbl[$];
        t_dir_row  row;
        t_grid_req q;
        int        settle;
        row = '{kind: ROW_REQ, addr: '0, value: 0, req: '{default: '0}, typed: 1'b0,
                res: '{default: '0}};

        // Small grid: either register below 2 gives a zero vector and the small status.
        row.kind = ROW_CFG; row.addr = AddrCols; row.value = 0;       rows_tbl.push_back(row);
        row.kind = ROW_REQ; row.req = '{CmdQuery, '0, '0, '0, '0, '0, 1'b1};
        row.typed = 1'b1; row.res = '{'0, '0, StatusSmall, 1'b1};       rows_tbl.push_back(row);
        row.kind = ROW_CFG; row.addr = AddrCols; row.value = 1;       rows_tbl.push_back(row);
        row.kind = ROW_REQ;
        row.req = '{CmdQuery, '1, 24'sh7FFFFF, -24'sd8388608, '1, '1, 1'b0};
        row.res = '{'0, '0, StatusSmall, 1'b0};                         rows_tbl.push_back(row);
        row.kind = ROW_CFG; row.addr = AddrCols; row.value = 63;      rows_tbl.push_back(row);
        row.kind = ROW_CFG; row.addr = AddrRows; row.value = 0;       rows_tbl.push_back(row);
        row.kind = ROW_REQ; row.req = '{CmdQuery, '0, 24'sd5, 24'sd5, '0, '0, 1'b1};
        row.res = '{'0, '0, StatusSmall, 1'b1};                         rows_tbl.push_back(row);
        row.kind = ROW_CFG; row.addr = AddrRows; row.value = 2;       rows_tbl.push_back(row);
        row.kind = ROW_CFG; row.addr = AddrCols; row.value = 2;       rows_tbl.push_back(row);
        // Unit 2x2 grid: 256 apart, u follows x and v follows y.
        row.kind = ROW_REQ; row.typed = 1'b0;
        row.req = '{CmdLoad, 10'd0, 24'sd0,   24'sd0,   24'sd0,   24'sd0,   1'b0}; rows_tbl.push_back(row);
        row.req = '{CmdLoad, 10'd1, 24'sd256, 24'sd0,   24'sd256, 24'sd0,   1'b1}; rows_tbl.push_back(row);
        row.req = '{CmdLoad, 10'd2, 24'sd0,   24'sd256, 24'sd0,   24'sd256, 1'b0}; rows_tbl.push_back(row);
        row.req = '{CmdLoad, 10'd3, 24'sd256, 24'sd256, 24'sd256, 24'sd256, 1'b0}; rows_tbl.push_back(row);
        row.req = '{CmdQuery, '0, 24'sd128, 24'sd128, '0, '0, 1'b1};
        row.typed = 1'b1; row.res = '{24'sd128, 24'sd128, StatusOk, 1'b1}; rows_tbl.push_back(row);
        // Extremes of the query point, beyond either end of the grid.
        row.typed = 1'b0;
        row.req = '{CmdQuery, '0, 24'sh7FFFFF, -24'sd8388608, '0, '0, 1'b0}; rows_tbl.push_back(row);
        row.req = '{CmdQuery, '1, -24'sd8388608, 24'sh7FFFFF, '1, '1, 1'b1}; rows_tbl.push_back(row);
        row.req = '{CmdLoad, 10'd1023, -24'sd8388608, 24'sh7FFFFF, -24'sd8388608, 24'sh7FFFFF, 1'b1};
        rows_tbl.push_back(row);
        // Coincident columns: x terms drop out, zero-gradient status.
        row.req = '{CmdLoad, 10'd1, 24'sd0, 24'sd0, 24'sh7FFFFF, -24'sd8388608, 1'b0};
        rows_tbl.push_back(row);
        row.req = '{CmdQuery, '0, 24'sd100, 24'sd100, '0, '0, 1'b0};
        row.typed = 1'b1; row.res = '{24'sd0, 24'sd100, StatusZero, 1'b0}; rows_tbl.push_back(row);
        // Steep y gradient: saturate both outputs.
        row.typed = 1'b0;
        row.req = '{CmdLoad, 10'd2, 24'sd0, 24'sd1, 24'sh7FFFFF, -24'sd8388608, 1'b0};
        rows_tbl.push_back(row);
        row.req = '{CmdQuery, '0, 24'sd0, 24'sh7FFFFF, '0, '0, 1'b1};  rows_tbl.push_back(row);
        row.req = '{CmdQuery, '0, 24'sd0, -24'sd8388608, '0, '0, 1'b0}; rows_tbl.push_back(row);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows_tbl[n]) begin
            if (rows_tbl[n].kind == ROW_CFG) write_reg(rows_tbl[n].addr, rows_tbl[n].value);
            else send_req(rows_tbl[n].req, rows_tbl[n].typed, rows_tbl[n].res);
        end

        run_phase(4, 3, 40);
        run_phase(63, 2, 40);
        run_phase(2, 63, 40);
        run_phase(7, 9, 40);
        quiet = 1'b1;
        run_phase(5, 63, 40);

        @(negedge i_clk);
        i_valid <= 1'b0;
        settle = 0;
        while (pending_vecs.size() != 0 && settle < 5000) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (IdleGap) @(posedge i_clk);
        if (pending_vecs.size() != 0) begin
            $error("%0d results never arrived", pending_vecs.size());
            fails++;
        end
        if (fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
